### hdl/lcsg_pkg.sv
// ----------------------------------------------------------------------------
// lcsg_pkg
// Shared types, register indexes and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package lcsg_pkg;

   localparam int PHASE_W         = 32;
   localparam int RATE_W          = 32;
   localparam int COUNT_REG_W     = 16;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int REQ_DATA_W      = 8;
   localparam int FIFO_DEPTH_BITS = 2;

   localparam int RESET_SAMPLE_COUNT = 1024;

   localparam logic [CSR_ADDR_W-1:0] REG_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CHIRP_RATE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_MODE   = 2'd2;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ROUND_Q30   = 64'd1 << 29;

   typedef struct packed {
      logic valid;
      logic active;
      logic last;
   } sample_ctrl_type;

   // divide a Taylor term by (2n)(2n+1)
   function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
      case (n)
         1:       return term / 64'd6;
         2:       return term / 64'd20;
         3:       return term / 64'd42;
         4:       return term / 64'd72;
         5:       return term / 64'd110;
         6:       return term / 64'd156;
         7:       return term / 64'd210;
         8:       return term / 64'd272;
         9:       return term / 64'd342;
         10:      return term / 64'd420;
         11:      return term / 64'd506;
         12:      return term / 64'd600;
         default: return term;
      endcase
   endfunction

   // one quarter-wave entry, Q30 Taylor series, rounded and clamped to amp_max
   function automatic logic [63:0] sine_entry(input int unsigned idx,
                                              input int unsigned t_bits,
                                              input logic [63:0] amp_max);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] amp;
      longint      sum;
      x    = (HALF_PI_Q30 * 64'(idx)) >> t_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
         term = (term * x2) >> 30;
         term = taylor_div(term, n);
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      amp = (64'(sum) * amp_max + ROUND_Q30) >> 30;
      if (amp > amp_max) begin
         amp = amp_max;
      end
      return amp;
   endfunction

endpackage

### hdl/lcsg_phase_gen.sv
// ----------------------------------------------------------------------------
// lcsg_phase_gen
// Control registers, phase and frequency accumulators and sample counter.
// ----------------------------------------------------------------------------
module lcsg_phase_gen #(
   parameter int TABLE_INDEX_BITS = 10,
   parameter int COUNT_BITS       = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [lcsg_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [lcsg_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   accept,
   input  logic                                   restart,
   output lcsg_pkg::sample_ctrl_type              s1_ctrl,
   output logic [TABLE_INDEX_BITS+1:0]            s1_phase
);

   localparam int CNT_W = (COUNT_BITS < lcsg_pkg::COUNT_REG_W) ?
                          COUNT_BITS : lcsg_pkg::COUNT_REG_W;
   localparam int PW    = lcsg_pkg::PHASE_W;
   localparam int TOP_W = TABLE_INDEX_BITS + 2;

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [lcsg_pkg::RATE_W-1:0]       rate_ff, rate_in;
   logic                              mode_ff, mode_in;
   logic [PW-1:0]                     phase_ff, phase_in;
   logic [PW-1:0]                     freq_ff, freq_in;
   logic [CNT_W-1:0]                  index_ff, index_in;
   logic                              running_ff, running_in;
   lcsg_pkg::sample_ctrl_type         s1_ctrl_ff, s1_ctrl_in;
   logic [TOP_W-1:0]                  s1_phase_ff, s1_phase_in;

   logic [CNT_W-1:0]                  half;
   logic [PW-1:0]                     step_mult;
   logic [PW-1:0]                     start_freq;
   logic [PW-1:0]                     phase_cur, freq_cur;
   logic [CNT_W-1:0]                  index_cur;
   logic                              run_cur;
   logic [CNT_W:0]                    index_inc;
   logic                              at_end;

   always_comb begin
      count_in = count_ff;
      rate_in  = rate_ff;
      mode_in  = mode_ff;
      if (csr_we) begin
         case (csr_addr)
            lcsg_pkg::REG_SAMPLE_COUNT: count_in = CNT_W'(csr_wdata[lcsg_pkg::COUNT_REG_W-1:0]);
            lcsg_pkg::REG_CHIRP_RATE:   rate_in  = csr_wdata[lcsg_pkg::RATE_W-1:0];
            lcsg_pkg::REG_PULSE_MODE:   mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign half       = count_ff >> 1;
   assign step_mult  = PW'(1) - PW'(half);
   assign start_freq = PW'(rate_ff * step_mult);

   always_comb begin
      if (restart) begin
         phase_cur = '0;
         freq_cur  = start_freq;
         index_cur = '0;
         run_cur   = (count_ff != '0);
      end else begin
         phase_cur = phase_ff;
         freq_cur  = freq_ff;
         index_cur = index_ff;
         run_cur   = running_ff;
      end
   end

   assign index_inc = {1'b0, index_cur} + (CNT_W+1)'(1);
   assign at_end    = index_inc >= {1'b0, count_ff};

   always_comb begin
      phase_in   = phase_ff;
      freq_in    = freq_ff;
      index_in   = index_ff;
      running_in = running_ff;
      if (accept) begin
         phase_in   = phase_cur;
         freq_in    = freq_cur;
         index_in   = index_cur;
         running_in = 1'b0;
         if (run_cur && !at_end) begin
            phase_in   = phase_cur + freq_cur;
            freq_in    = freq_cur + rate_ff;
            index_in   = index_inc[CNT_W-1:0];
            running_in = 1'b1;
         end
      end
      s1_ctrl_in.valid  = accept;
      s1_ctrl_in.active = run_cur;
      s1_ctrl_in.last   = run_cur && at_end;
      s1_phase_in       = mode_ff ? '0 : phase_cur[PW-1 -: TOP_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= CNT_W'(lcsg_pkg::RESET_SAMPLE_COUNT);
         rate_ff    <= '0;
         mode_ff    <= 1'b0;
         phase_ff   <= '0;
         freq_ff    <= '0;
         index_ff   <= '0;
         running_ff <= 1'b0;
         s1_ctrl_ff <= '0;
      end else begin
         count_ff   <= count_in;
         rate_ff    <= rate_in;
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         freq_ff    <= freq_in;
         index_ff   <= index_in;
         running_ff <= running_in;
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_phase_ff <= s1_phase_in;
   end

   assign s1_ctrl  = s1_ctrl_ff;
   assign s1_phase = s1_phase_ff;

endmodule

### hdl/lcsg_sine_lookup.sv
// ----------------------------------------------------------------------------
// lcsg_sine_lookup
// Quarter-wave sine ROM with two registered read ports and quadrant mapping.
// ----------------------------------------------------------------------------
module lcsg_sine_lookup #(
   parameter int TABLE_INDEX_BITS = 10,
   parameter int AMPLITUDE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lcsg_pkg::sample_ctrl_type           in_ctrl,
   input  logic [TABLE_INDEX_BITS+1:0]         in_phase,
   output lcsg_pkg::sample_ctrl_type           out_ctrl,
   output logic signed [AMPLITUDE_BITS-1:0]    cos_value,
   output logic signed [AMPLITUDE_BITS-1:0]    sin_value
);

   localparam int T          = TABLE_INDEX_BITS;
   localparam int AW         = AMPLITUDE_BITS;
   localparam int TABLE_SIZE = (1 << T) + 1;
   localparam logic [63:0]  AMP_MAX = (64'd1 << (AW - 1)) - 64'd1;
   localparam logic [T:0]   QUARTER = (T+1)'(1) << T;

   typedef logic [AW-2:0] rom_type [TABLE_SIZE];

   function automatic rom_type build_rom();
      rom_type t;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         t[i] = (AW-1)'(lcsg_pkg::sine_entry(i, T, AMP_MAX));
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [T:0]                   addr_a, addr_b;
   logic [AW-2:0]                rom_a_ff, rom_b_ff;
   logic [1:0]                   quad_ff;
   lcsg_pkg::sample_ctrl_type    ctrl_ff;
   logic signed [AW-1:0]         a_pos, b_pos, a_neg, b_neg;

   assign addr_a = {1'b0, in_phase[T-1:0]};
   assign addr_b = QUARTER - addr_a;

   always_ff @(posedge clock) begin
      rom_a_ff <= SINE_ROM[addr_a];
      rom_b_ff <= SINE_ROM[addr_b];
      quad_ff  <= in_phase[T+1:T];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= in_ctrl;
      end
   end

   assign a_pos = signed'({1'b0, rom_a_ff});
   assign b_pos = signed'({1'b0, rom_b_ff});
   assign a_neg = -a_pos;
   assign b_neg = -b_pos;

   always_comb begin
      case (quad_ff)
         2'd0: begin
            sin_value = a_pos;
            cos_value = b_pos;
         end
         2'd1: begin
            sin_value = b_pos;
            cos_value = a_neg;
         end
         2'd2: begin
            sin_value = a_neg;
            cos_value = b_neg;
         end
         default: begin
            sin_value = b_neg;
            cos_value = a_pos;
         end
      endcase
      if (!ctrl_ff.active) begin
         sin_value = '0;
         cos_value = '0;
      end
   end

   assign out_ctrl = ctrl_ff;

endmodule

### hdl/lcsg_out_fifo.sv
// ----------------------------------------------------------------------------
// lcsg_out_fifo
// Small result queue that decouples the pipeline from the rsp stall.
// ----------------------------------------------------------------------------
module lcsg_out_fifo #(
   parameter int WIDTH      = 34,
   parameter int DEPTH_BITS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic                   out_valid,
   output logic [WIDTH-1:0]       out_data,
   output logic [DEPTH_BITS:0]    count
);

   localparam int DEPTH = 1 << DEPTH_BITS;

   logic [WIDTH-1:0]       mem_ff [DEPTH];
   logic [DEPTH_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_BITS:0]    count_ff, count_in;
   logic                   do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign wr_ptr_in = push ? wr_ptr_ff + DEPTH_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + DEPTH_BITS'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + (DEPTH_BITS+1)'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - (DEPTH_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### hdl/lfm_chirp_sample_generator_core.sv
// ----------------------------------------------------------------------------
// lfm_chirp_sample_generator_core
// Linear FM chirp / rectangular pulse sample generator, one I/Q beat per req.
// ----------------------------------------------------------------------------
// Each req beat carries a restart flag in req_tdata[0]; every beat yields one
// rsp beat with cosine (low half) and sine (high half) of the pulse phase.
// rsp_tlast marks the final sample of a pulse, rsp_tuser is high while a pulse
// sample is output; once the pulse ends, beats are zero with rsp_tuser low.
// Write sample_count, chirp_rate and pulse_mode through csr_we/csr_addr/
// csr_wdata only while no beats are in flight.
// The rsp beat for an accepted req passes the registered phase stage, the
// registered ROM read and the result queue before it is offered on rsp.
// Throughput: one beat per cycle sustained while rsp_tready stays high.
// A four-entry result queue sits before rsp; req_tready depends on registers
// only and stays high while the queue plus pipeline hold fewer than four beats,
// so a stalled receiver is absorbed before req_tready drops.
// Reset clears the accumulators, stops any pulse, empties the queue and loads
// sample_count 1024, chirp_rate 0 and pulse_mode chirp.
// ----------------------------------------------------------------------------
module lfm_chirp_sample_generator_core #(
   parameter int TABLE_INDEX_BITS = 10,
   parameter int AMPLITUDE_BITS   = 16,
   parameter int COUNT_BITS       = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lcsg_pkg::REQ_DATA_W-1:0]       req_tdata,   // [0] restart
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((2*AMPLITUDE_BITS+7)/8)*8-1:0] rsp_tdata,   // in_phase, quadrature
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser,   // active
   input  logic                                  csr_we,
   input  logic [lcsg_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [lcsg_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW      = AMPLITUDE_BITS;
   localparam int DATA_W  = ((2*AW+7)/8)*8;
   localparam int ENTRY_W = 2*AW + 2;
   localparam int DB      = lcsg_pkg::FIFO_DEPTH_BITS;
   localparam logic [DB:0] FIFO_DEPTH = (DB+1)'(1) << DB;

   lcsg_pkg::sample_ctrl_type       s1_ctrl, s2_ctrl;
   logic [TABLE_INDEX_BITS+1:0]     s1_phase;
   logic signed [AW-1:0]            cos_value, sin_value;
   logic                            req_accept, rsp_accept;
   logic [DB:0]                     fifo_count;
   logic [DB:0]                     pending;
   logic [ENTRY_W-1:0]              push_data, out_data;

   assign pending    = fifo_count + (DB+1)'(s1_ctrl.valid) + (DB+1)'(s2_ctrl.valid);
   assign req_tready = pending < FIFO_DEPTH;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   lcsg_phase_gen #(
      .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
      .COUNT_BITS       (COUNT_BITS)
   ) u_phase_gen (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .accept    (req_accept),
      .restart   (req_tdata[0]),
      .s1_ctrl   (s1_ctrl),
      .s1_phase  (s1_phase)
   );

   lcsg_sine_lookup #(
      .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
      .AMPLITUDE_BITS   (AMPLITUDE_BITS)
   ) u_sine_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_ctrl   (s1_ctrl),
      .in_phase  (s1_phase),
      .out_ctrl  (s2_ctrl),
      .cos_value (cos_value),
      .sin_value (sin_value)
   );

   assign push_data = {s2_ctrl.last, s2_ctrl.active, sin_value, cos_value};

   lcsg_out_fifo #(
      .WIDTH      (ENTRY_W),
      .DEPTH_BITS (DB)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_ctrl.valid),
      .push_data (push_data),
      .pop       (rsp_accept),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_tdata = DATA_W'(out_data[2*AW-1:0]);
   assign rsp_tuser = out_data[2*AW];
   assign rsp_tlast = out_data[2*AW+1];

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(s2_ctrl.valid && fifo_count == FIFO_DEPTH && !rsp_accept))
      else $error("result queue overflow");

   a_stage_follows_accept: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> s1_ctrl.valid == $past(req_accept))
      else $error("phase stage out of step with accepted beats");

   a_idle_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("inactive beat carries data");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= FIFO_DEPTH)
      else $error("more beats in flight than queue space");
`endif

endmodule
